FILE: sv/pmiw_pkg.sv
// ----------------------------------------------------------------------------
// pmiw_pkg
// Shared constants and types for the minimum image wrap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pmiw_pkg;

    // Default coordinate width (Q12.12)
    localparam int COORD_WIDTH_DEF = 24;

    // Packed lattice / reciprocal register layout
    localparam int FIELD_W   = 21;
    localparam int LATTICE_W = 3 * FIELD_W;

    // Cutoff register
    localparam int                  CUTOFF_W     = 40;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 40'd419430400;

    // Dot product has 30 fraction bits; lattice Q10.10 lifted to Q10.12
    localparam int ROUND_SHIFT = 30;
    localparam int LAT_SHIFT   = 2;

    // APB port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    // Register indexes (byte address = 8 * index)
    typedef enum logic [2:0] {
        REG_A1  = 3'd0,
        REG_A2  = 3'd1,
        REG_A3  = 3'd2,
        REG_B1  = 3'd3,
        REG_B2  = 3'd4,
        REG_B3  = 3'd5,
        REG_CUT = 3'd6
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: sv/periodic_minimum_image_wrap.sv
// ----------------------------------------------------------------------------
// periodic_minimum_image_wrap
// Minimum image wrap of a Q12.12 displacement vector against a lattice:
// cutoff test on the squared length, then three reduction passes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  s_      | in        | s_valid / s_ready    | s_vec_x, s_vec_y, s_vec_z
//  m_      | out       | m_valid / m_ready    | m_wrapped_x/y/z, m_was_wrapped
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
//  One item per cycle while m_ready holds high; two register stages for the
//  squared length and cutoff compare, four per reduction pass (dot product,
//  rounding, lattice multiply, subtract/saturate).
//  Reset is synchronous: valids clear, registers take their reset values.
//  Each stage holds while its successor is full and stalled; empty stages
//  fill behind a stalled output, so input keeps flowing until the pipe fills.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_minimum_image_wrap
    import pmiw_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,
    // Input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_vec_x,
    input  logic signed [COORD_WIDTH-1:0] s_vec_y,
    input  logic signed [COORD_WIDTH-1:0] s_vec_z,
    // Result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_wrapped_x,
    output logic signed [COORD_WIDTH-1:0] m_wrapped_y,
    output logic signed [COORD_WIDTH-1:0] m_wrapped_z,
    output logic                          m_was_wrapped
);

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int CMP_W = (SQ_W + 2 > CUTOFF_W) ? SQ_W + 2 : CUTOFF_W;

    // Configuration registers
    logic [LATTICE_W-1:0] lat_reg [3];
    logic [LATTICE_W-1:0] rcp_reg [3];
    logic [CUTOFF_W-1:0]  cut_reg;
    logic [2:0]           reg_idx;
    logic                 apb_wr;

    // Stage A: component squares
    logic signed [COORD_WIDTH-1:0] in_vec      [3];
    logic signed [SQ_W-1:0]        sq_signed   [3];
    logic [SQ_W-1:0]               a_sq_reg    [3];
    logic signed [COORD_WIDTH-1:0] a_vec_reg   [3];
    logic                          a_vld_reg;
    logic                          en_a;

    // Stage B: squared length vs cutoff
    logic [CMP_W-1:0]              sq_sum;
    logic                          b_wrap_next;
    logic signed [COORD_WIDTH-1:0] b_vec_reg   [3];
    logic                          b_wrap_reg;
    logic                          b_vld_reg;
    logic                          en_b;

    // Between passes
    logic                          p_valid [4];
    logic                          p_ready [4];
    logic signed [COORD_WIDTH-1:0] p_vec   [4][3];
    logic                          p_wrap  [4];

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign apb_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                lat_reg[i] <= '0;
                rcp_reg[i] <= '0;
            end
            cut_reg <= CUTOFF_RESET;
        end else if (apb_wr) begin
            case (reg_idx)
                REG_A1:  lat_reg[0] <= pwdata[LATTICE_W-1:0];
                REG_A2:  lat_reg[1] <= pwdata[LATTICE_W-1:0];
                REG_A3:  lat_reg[2] <= pwdata[LATTICE_W-1:0];
                REG_B1:  rcp_reg[0] <= pwdata[LATTICE_W-1:0];
                REG_B2:  rcp_reg[1] <= pwdata[LATTICE_W-1:0];
                REG_B3:  rcp_reg[2] <= pwdata[LATTICE_W-1:0];
                REG_CUT: cut_reg    <= pwdata[CUTOFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_A1:  prdata = APB_DATA_W'(lat_reg[0]);
            REG_A2:  prdata = APB_DATA_W'(lat_reg[1]);
            REG_A3:  prdata = APB_DATA_W'(lat_reg[2]);
            REG_B1:  prdata = APB_DATA_W'(rcp_reg[0]);
            REG_B2:  prdata = APB_DATA_W'(rcp_reg[1]);
            REG_B3:  prdata = APB_DATA_W'(rcp_reg[2]);
            REG_CUT: prdata = APB_DATA_W'(cut_reg);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front stages: squared length and cutoff test
    // ------------------------------------------------------------------
    assign in_vec[0] = s_vec_x;
    assign in_vec[1] = s_vec_y;
    assign in_vec[2] = s_vec_z;

    assign en_b    = !b_vld_reg || p_ready[0];
    assign en_a    = !a_vld_reg || en_b;
    assign s_ready = en_a;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_signed[i] = in_vec[i] * in_vec[i];
        end
        sq_sum = CMP_W'(a_sq_reg[0]) + CMP_W'(a_sq_reg[1]) + CMP_W'(a_sq_reg[2]);
        // strictly greater: equal length does not wrap
        b_wrap_next = sq_sum > CMP_W'(cut_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (en_a) a_vld_reg <= s_valid;
            if (en_b) b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            for (int i = 0; i < 3; i++) begin
                a_sq_reg[i] <= sq_signed[i];
            end
            a_vec_reg <= in_vec;
        end
        if (en_b) begin
            b_vec_reg  <= a_vec_reg;
            b_wrap_reg <= b_wrap_next;
        end
    end

    assign p_valid[0] = b_vld_reg;
    assign p_vec[0]   = b_vec_reg;
    assign p_wrap[0]  = b_wrap_reg;

    // ------------------------------------------------------------------
    // Three reduction passes, a1/b1 then a2/b2 then a3/b3
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 3; k++) begin : g_pass
        pmiw_pass #(
            .COORD_W (COORD_WIDTH)
        ) u_pass (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .lattice   (lat_reg[k]),
            .recip     (rcp_reg[k]),
            .in_valid  (p_valid[k]),
            .in_ready  (p_ready[k]),
            .in_vec    (p_vec[k]),
            .in_wrap   (p_wrap[k]),
            .out_valid (p_valid[k+1]),
            .out_ready (p_ready[k+1]),
            .out_vec   (p_vec[k+1]),
            .out_wrap  (p_wrap[k+1])
        );
    end

    assign p_ready[3]    = m_ready;
    assign m_valid       = p_valid[3];
    assign m_wrapped_x   = p_vec[3][0];
    assign m_wrapped_y   = p_vec[3][1];
    assign m_wrapped_z   = p_vec[3][2];
    assign m_was_wrapped = p_wrap[3];

`ifndef ASSERT_OFF
    // Input only backs up when the first stage holds an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> a_vld_reg)
        else $error("input stalled with empty first stage");

    // A stalled front stage keeps its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        a_vld_reg && !en_b |=> a_vld_reg && $stable(a_vec_reg[0]))
        else $error("front stage lost item under stall");

    // Reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !a_vld_reg && !b_vld_reg)
        else $error("valid survived reset");
`endif

endmodule

`default_nettype wire

FILE: sv/pmiw_pass.sv
// ----------------------------------------------------------------------------
// pmiw_pass
// One reduction pass v -= a * floor(b.v + 1/2), four register stages,
// applied only when the item's wrap flag is set. Saturates to COORD_W.
// ----------------------------------------------------------------------------
`default_nettype none

module pmiw_pass
    import pmiw_pkg::*;
#(
    parameter int COORD_W = COORD_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [LATTICE_W-1:0]      lattice,
    input  logic [LATTICE_W-1:0]      recip,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [COORD_W-1:0] in_vec [3],
    input  logic                      in_wrap,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_vec [3],
    output logic                      out_wrap
);

    localparam int PROD_W = FIELD_W + COORD_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int N_W    = DOT_W - ROUND_SHIFT;
    localparam int MUL_W  = FIELD_W + N_W;
    localparam int LP_W   = MUL_W + LAT_SHIFT;
    localparam int D_W    = LP_W + 1;

    localparam logic signed [D_W-1:0] SAT_HI =
        D_W'((longint'(1) <<< (COORD_W - 1)) - longint'(1));
    localparam logic signed [D_W-1:0] SAT_LO = -SAT_HI - D_W'(1);
    localparam logic signed [DOT_W-1:0] ROUND_HALF =
        DOT_W'(longint'(1) <<< (ROUND_SHIFT - 1));

    // Unpacked lattice / reciprocal components
    logic signed [FIELD_W-1:0] a_c [3];
    logic signed [FIELD_W-1:0] b_c [3];

    // Stage valids and advance enables
    logic [3:0] vld_reg;
    logic [3:0] en;

    // Stage 0: b.v partial products
    logic signed [PROD_W-1:0]  s0_prod_reg  [3];
    logic signed [PROD_W-1:0]  s0_prod_next [3];
    logic signed [COORD_W-1:0] s0_vec_reg   [3];
    logic                      s0_wrap_reg;

    // Stage 1: rounded multiple n
    logic signed [DOT_W-1:0]   dot_sum;
    logic signed [N_W-1:0]     s1_n_reg;
    logic signed [N_W-1:0]     s1_n_next;
    logic signed [COORD_W-1:0] s1_vec_reg [3];
    logic                      s1_wrap_reg;

    // Stage 2: n * a (Q28.12 at the default COORD_W)
    logic signed [MUL_W-1:0]   s2_mul       [3];
    logic signed [LP_W-1:0]    s2_prod_reg  [3];
    logic signed [LP_W-1:0]    s2_prod_next [3];
    logic signed [COORD_W-1:0] s2_vec_reg   [3];
    logic                      s2_wrap_reg;

    // Stage 3: subtract and saturate
    logic signed [D_W-1:0]     diff        [3];
    logic signed [COORD_W-1:0] s3_vec_reg  [3];
    logic signed [COORD_W-1:0] s3_vec_next [3];
    logic                      s3_wrap_reg;

    // Component extraction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_c[i] = lattice[FIELD_W*i +: FIELD_W];
            b_c[i] = recip[FIELD_W*i +: FIELD_W];
        end
    end

    // Stall chain: a stage moves when empty or when its successor moves
    always_comb begin
        en[3] = !vld_reg[3] || out_ready;
        en[2] = !vld_reg[2] || en[3];
        en[1] = !vld_reg[1] || en[2];
        en[0] = !vld_reg[0] || en[1];
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            if (en[1]) vld_reg[1] <= vld_reg[0];
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // Datapath next values
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s0_prod_next[i] = b_c[i] * in_vec[i];
        end

        dot_sum = DOT_W'(s0_prod_reg[0]) + DOT_W'(s0_prod_reg[1])
                + DOT_W'(s0_prod_reg[2]) + ROUND_HALF;
        // floor of (dot + half) / 2^30
        s1_n_next = dot_sum[DOT_W-1:ROUND_SHIFT];

        for (int i = 0; i < 3; i++) begin
            s2_mul[i]       = a_c[i] * s1_n_reg;
            s2_prod_next[i] = {s2_mul[i], {LAT_SHIFT{1'b0}}};
        end

        for (int i = 0; i < 3; i++) begin
            diff[i] = D_W'(s2_vec_reg[i]) - D_W'(s2_prod_reg[i]);
            if (!s2_wrap_reg) begin
                s3_vec_next[i] = s2_vec_reg[i];
            end else if (diff[i] > SAT_HI) begin
                s3_vec_next[i] = SAT_HI[COORD_W-1:0];
            end else if (diff[i] < SAT_LO) begin
                s3_vec_next[i] = SAT_LO[COORD_W-1:0];
            end else begin
                s3_vec_next[i] = diff[i][COORD_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s0_prod_reg <= s0_prod_next;
            s0_vec_reg  <= in_vec;
            s0_wrap_reg <= in_wrap;
        end
        if (en[1]) begin
            s1_n_reg    <= s1_n_next;
            s1_vec_reg  <= s0_vec_reg;
            s1_wrap_reg <= s0_wrap_reg;
        end
        if (en[2]) begin
            s2_prod_reg <= s2_prod_next;
            s2_vec_reg  <= s1_vec_reg;
            s2_wrap_reg <= s1_wrap_reg;
        end
        if (en[3]) begin
            s3_vec_reg  <= s3_vec_next;
            s3_wrap_reg <= s2_wrap_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_vec   = s3_vec_reg;
    assign out_wrap  = s3_wrap_reg;

endmodule

`default_nettype wire
